// ===== src/sct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Types and character codes shared by the command tokenizer front end,
// queue and back end.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Result kinds as seen on the output port
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOT  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    // Operations handed from the front end to the back end
    typedef enum logic [1:0] {
        OPC_CHAR    = 2'd0,  // feed one character to the back end
        OPC_NOP     = 2'd1,  // no work, only carries the end-of-byte mark
        OPC_EOL     = 2'd2,  // end the line
        OPC_EOL_RST = 2'd3   // end the line, then return to reset state
    } t_opc;

    typedef struct packed {
        t_opc       code;
        logic [7:0] sym;
        logic       item_end;  // last op caused by one input byte
    } t_op;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

endpackage : sct_pkg
`default_nettype wire

// ===== src/shell_command_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_tokenizer_core
// Command-line tokenizer: bytes in, token characters / end-of-token /
// end-of-line marks out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                   Payload
//  -------  ---------  --------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_ready     i_byte_in, i_line_last
//  out      source     o_out_valid / i_out_ready   o_out_kind, o_symbol, o_run_last
//
//  Flow: the front end issues one queue op per cycle while the queue has room:
//  one op per resolved byte plus a close op per transaction, so a plain byte
//  yields its char op and the close op; a redirection adds the spaces around
//  it as extra ops. The back end decodes each op into its results and an
//  end-of-byte flush and takes them one per cycle while the output is free;
//  results leave through a one-entry hold plus output register.
//  Reset: synchronous, active low; all control state clears on reset.
//  Stalls: the op queue (FIFO_DEPTH entries) lets front and back stall apart;
//  an output stall holds the back end while the front keeps taking bytes
//  until the queue fills, then o_in_ready drops.
//
// Front end: tracks quotes and spaces out unquoted >, >>, <, <>, 2> and
// 2>&1, holding up to four bytes until the pattern is decided. A zero byte
// or the last flag resolves the held bytes as if nothing follows and closes
// the line; the last flag also returns all state to reset.
// Back end: drops quote chars, folds unquoted blank runs into one separator,
// handles backslash escapes inside quotes and tracks the empty-token rule.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_core import sct_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_line_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_symbol,
    output logic            o_run_last
);

    // front -> queue
    logic  fr_push;
    logic  q_ready;
    t_op   fr_op;
    // queue -> back
    logic  q_valid;
    logic  bk_ready;
    t_op   q_op;
    t_kind bk_kind;

    sct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_in    (i_byte_in),
        .i_line_last  (i_line_last),
        .o_push       (fr_push),
        .o_op         (fr_op),
        .i_push_ready (q_ready)
    );

    sct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .o_ready (q_ready),
        .i_data  (fr_op),
        .o_valid (q_valid),
        .i_pop   (bk_ready),
        .o_data  (q_op)
    );

    sct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (bk_ready),
        .i_op        (q_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_kind  (bk_kind),
        .o_symbol    (o_symbol),
        .o_run_last  (o_run_last)
    );

    assign o_out_kind = bk_kind;

endmodule : shell_command_tokenizer_core
`default_nettype wire

// ===== src/sct_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Byte intake, quote tracking and redirection spacing with a small
// lookahead buffer; issues one back-end op per cycle while the queue has room.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_line_last,
    output logic            o_push,
    output t_op             o_op,
    input  wire logic       i_push_ready
);

    logic       r_busy;
    logic       r_at_end;
    logic       r_last;
    logic       r_sq;
    logic       r_dq;
    logic [2:0] r_cnt;
    logic [7:0] r_buf [0:3];
    logic [7:0] r_str [0:4];
    logic [2:0] r_slen;

    logic       n_sq, n_dq, unq, brk, done, fire;
    logic [7:0] pat [0:5];
    logic [2:0] plen, used;
    logic [7:0] sh  [0:3];
    logic       accept, byte_nz;

    // One resolve step on the head of the lookahead buffer
    always_comb begin
        n_sq = r_sq ^ (r_buf[0] == CH_SQ);
        n_dq = r_dq ^ (r_buf[0] == CH_DQ);
        unq  = !n_sq && !n_dq;
        brk  = 1'b0;
        plen = 3'd1;
        used = 3'd1;
        for (int i = 0; i < 6; i++) begin
            pat[i] = CH_NUL;
        end
        pat[0] = r_buf[0];
        if (unq && r_buf[0] == CH_TWO) begin
            if (r_cnt < 3'd2 && !r_at_end) begin
                brk = 1'b1;
            end else if (r_cnt >= 3'd2 && r_buf[1] == CH_GT) begin
                if (r_cnt < 3'd3 && !r_at_end) begin
                    brk = 1'b1;
                end else if (r_cnt == 3'd3 && r_buf[2] == CH_AMP && !r_at_end) begin
                    brk = 1'b1;
                end else if (r_cnt == 3'd4 && r_buf[2] == CH_AMP && r_buf[3] == CH_ONE) begin
                    pat[0] = CH_SPACE;
                    pat[1] = CH_TWO;
                    pat[2] = CH_GT;
                    pat[3] = CH_AMP;
                    pat[4] = CH_ONE;
                    pat[5] = CH_SPACE;
                    plen   = 3'd6;
                    used   = 3'd4;
                end else begin
                    pat[0] = CH_SPACE;
                    pat[1] = CH_TWO;
                    pat[2] = CH_GT;
                    pat[3] = CH_SPACE;
                    plen   = 3'd4;
                    used   = 3'd2;
                end
            end
        end else if (unq && (r_buf[0] == CH_GT || r_buf[0] == CH_LT)) begin
            if (r_cnt < 3'd2 && !r_at_end) begin
                brk = 1'b1;
            end else if (r_cnt >= 3'd2 && r_buf[1] == CH_GT) begin
                pat[0] = CH_SPACE;
                pat[1] = r_buf[0];
                pat[2] = CH_GT;
                pat[3] = CH_SPACE;
                plen   = 3'd4;
                used   = 3'd2;
            end else begin
                pat[0] = CH_SPACE;
                pat[1] = r_buf[0];
                pat[2] = CH_SPACE;
                plen   = 3'd3;
            end
        end
        done = (r_cnt == 3'd0) || brk;
    end

    // Buffer after dropping the consumed bytes
    always_comb begin
        sh[0] = (used == 3'd1) ? r_buf[1] : (used == 3'd2) ? r_buf[2] : CH_NUL;
        sh[1] = (used == 3'd1) ? r_buf[2] : (used == 3'd2) ? r_buf[3] : CH_NUL;
        sh[2] = (used == 3'd1) ? r_buf[3] : CH_NUL;
        sh[3] = CH_NUL;
    end

    // Op selection: pending pattern chars, then a new step, then the close op
    always_comb begin
        o_op.item_end = 1'b0;
        o_op.code     = OPC_CHAR;
        o_op.sym      = CH_NUL;
        if (r_slen != 3'd0) begin
            o_op.sym = r_str[0];
        end else if (!done) begin
            o_op.sym = pat[0];
        end else begin
            o_op.item_end = 1'b1;
            if (r_at_end) begin
                o_op.code = r_last ? OPC_EOL_RST : OPC_EOL;
            end else begin
                o_op.code = OPC_NOP;
            end
        end
    end

    assign o_push     = r_busy;
    assign fire       = r_busy && i_push_ready;
    assign o_in_ready = !r_busy || (i_push_ready && r_slen == 3'd0 && done);
    assign accept     = i_in_valid && o_in_ready;
    assign byte_nz    = (i_byte_in != CH_NUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_at_end <= 1'b0;
            r_last   <= 1'b0;
            r_sq     <= 1'b0;
            r_dq     <= 1'b0;
            r_cnt    <= 3'd0;
            r_slen   <= 3'd0;
        end else begin
            if (fire) begin
                if (r_slen != 3'd0) begin
                    r_slen <= r_slen - 3'd1;
                end else if (!done) begin
                    r_sq   <= n_sq;
                    r_dq   <= n_dq;
                    r_slen <= plen - 3'd1;
                    r_cnt  <= r_cnt - used;
                end else begin
                    // a byte taken with the close op keeps the front busy
                    if (!accept) begin
                        r_busy <= 1'b0;
                    end
                    if (r_last) begin
                        r_sq <= 1'b0;
                        r_dq <= 1'b0;
                    end
                end
            end
            if (accept) begin
                r_busy   <= 1'b1;
                r_at_end <= i_line_last || !byte_nz;
                r_last   <= i_line_last;
                if (byte_nz) begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_slen != 3'd0) begin
                for (int i = 0; i < 4; i++) begin
                    r_str[i] <= r_str[i+1];
                end
            end else if (!done) begin
                for (int i = 0; i < 5; i++) begin
                    r_str[i] <= pat[i+1];
                end
                for (int i = 0; i < 4; i++) begin
                    r_buf[i] <= sh[i];
                end
            end
        end
        if (accept && byte_nz) begin
            for (int i = 0; i < 4; i++) begin
                if (r_cnt[1:0] == 2'(i)) begin
                    r_buf[i] <= i_byte_in;
                end
            end
        end
    end

    // A step that consumes bytes always shrinks the buffer
    a_step_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_slen == 3'd0 && !done |=> r_cnt < $past(r_cnt))
        else $error("front step did not consume lookahead");

    // Idle front always has room for one more byte and nothing pending
    a_idle_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_slen == 3'd0) && (r_cnt <= 3'd3))
        else $error("front idle with pending work");

endmodule : sct_front
`default_nettype wire

// ===== src/sct_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_fifo
// Short op queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sct_fifo import sct_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_ready,
    input  wire t_op  i_data,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_op       o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("op queue overflow");

endmodule : sct_fifo
`default_nettype wire

// ===== src/sct_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Quote stripping, blank folding, escapes and line ending; one result a cycle
// while the output is free, last-result marking through a one-entry hold stage.
// ----------------------------------------------------------------------------
module sct_back import sct_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    output logic      o_op_ready,
    input  wire t_op  i_op,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_kind     o_out_kind,
    output logic [7:0] o_symbol,
    output logic      o_run_last
);

    typedef struct packed {
        logic       flush;
        t_kind      kind;
        logic [7:0] sym;
    } t_evt;

    function automatic t_evt mk_evt(input logic flush, input t_kind kind,
                                    input logic [7:0] sym);
        t_evt e;
        e.flush = flush;
        e.kind  = kind;
        e.sym   = sym;
        return e;
    endfunction

    logic       r_sq, r_dq, r_esc, r_inb, r_tn, r_stop;
    logic [1:0] r_pcnt;
    t_evt       r_pend [0:1];
    logic       r_hold_v;
    t_evt       r_hold;
    logic       r_o_valid;
    t_kind      r_o_kind;
    logic [7:0] r_o_sym;
    logic       r_o_last;

    logic       s_sq, s_dq, s_esc, s_inb, s_tn, s_stop;
    t_evt       ev [0:2];
    logic [1:0] k;
    logic [7:0] c;
    logic       quoted, out_free, pop, ex_v, push;
    t_evt       ex;

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_op_ready = (r_pcnt == 2'd0) && out_free;
    assign pop        = i_op_valid && o_op_ready;

    // Decode one op into up to three events and the next back-end state
    always_comb begin
        s_sq   = r_sq;
        s_dq   = r_dq;
        s_esc  = r_esc;
        s_inb  = r_inb;
        s_tn   = r_tn;
        s_stop = r_stop;
        k      = 2'd0;
        for (int i = 0; i < 3; i++) begin
            ev[i] = mk_evt(1'b0, KIND_CHAR, CH_NUL);
        end
        c      = i_op.sym;
        quoted = r_sq || r_dq;
        unique case (i_op.code)
            OPC_CHAR: begin
                if (!r_stop) begin
                    if (c == CH_LF) begin
                        if (r_tn) begin
                            ev[k] = mk_evt(1'b0, KIND_EOT, CH_NUL);
                            k     = k + 2'd1;
                        end
                        ev[k]  = mk_evt(1'b0, KIND_EOL, CH_NUL);
                        k      = k + 2'd1;
                        s_tn   = 1'b0;
                        s_stop = 1'b1;
                    end else if (c == CH_SPACE || c == CH_TAB) begin
                        if (quoted) begin
                            s_inb = 1'b0;
                            ev[k] = mk_evt(1'b0, KIND_CHAR, c);
                            k     = k + 2'd1;
                            s_tn  = 1'b1;
                        end else if (!r_inb) begin
                            s_inb = 1'b1;
                            if (r_tn) begin
                                ev[k] = mk_evt(1'b0, KIND_EOT, CH_NUL);
                                s_tn  = 1'b0;
                            end else begin
                                // empty token ends the line
                                ev[k]  = mk_evt(1'b0, KIND_EOL, CH_NUL);
                                s_stop = 1'b1;
                            end
                            k = k + 2'd1;
                        end
                    end else begin
                        s_inb = 1'b0;
                        if (c == CH_SQ) begin
                            s_sq = !r_sq;
                        end else if (c == CH_DQ) begin
                            s_dq = !r_dq;
                        end else if (c == CH_BSL && quoted) begin
                            s_esc = 1'b1;
                        end else if (r_esc) begin
                            s_esc = 1'b0;
                            s_tn  = 1'b1;
                            if (c == CH_N) begin
                                ev[k] = mk_evt(1'b0, KIND_CHAR, CH_LF);
                                k     = k + 2'd1;
                            end else if (c == CH_T) begin
                                ev[k] = mk_evt(1'b0, KIND_CHAR, CH_TAB);
                                k     = k + 2'd1;
                            end else begin
                                ev[k] = mk_evt(1'b0, KIND_CHAR, CH_BSL);
                                k     = k + 2'd1;
                                ev[k] = mk_evt(1'b0, KIND_CHAR, c);
                                k     = k + 2'd1;
                            end
                        end else begin
                            ev[k] = mk_evt(1'b0, KIND_CHAR, c);
                            k     = k + 2'd1;
                            s_tn  = 1'b1;
                        end
                    end
                end
            end
            OPC_NOP: begin
            end
            OPC_EOL, OPC_EOL_RST: begin
                if (!r_stop) begin
                    if (r_tn) begin
                        ev[k] = mk_evt(1'b0, KIND_EOT, CH_NUL);
                        k     = k + 2'd1;
                    end
                    ev[k]  = mk_evt(1'b0, KIND_EOL, CH_NUL);
                    k      = k + 2'd1;
                    s_tn   = 1'b0;
                    s_stop = 1'b1;
                end
                if (i_op.code == OPC_EOL_RST) begin
                    s_sq   = 1'b0;
                    s_dq   = 1'b0;
                    s_esc  = 1'b0;
                    s_inb  = 1'b0;
                    s_tn   = 1'b0;
                    s_stop = 1'b0;
                end
            end
        endcase
        if (i_op.item_end) begin
            ev[k] = mk_evt(1'b1, KIND_CHAR, CH_NUL);
            k     = k + 2'd1;
        end
    end

    // Event taken this cycle: first event of a fresh op, or a pending one
    always_comb begin
        ex_v = 1'b0;
        ex   = ev[0];
        if (pop) begin
            ex_v = (k != 2'd0);
        end else if (r_pcnt != 2'd0 && out_free) begin
            ex_v = 1'b1;
            ex   = r_pend[0];
        end
    end

    // The held result leaves once it is known whether it closes its byte
    assign push = ex_v && r_hold_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq      <= 1'b0;
            r_dq      <= 1'b0;
            r_esc     <= 1'b0;
            r_inb     <= 1'b0;
            r_tn      <= 1'b0;
            r_stop    <= 1'b0;
            r_pcnt    <= 2'd0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_sq   <= s_sq;
                r_dq   <= s_dq;
                r_esc  <= s_esc;
                r_inb  <= s_inb;
                r_tn   <= s_tn;
                r_stop <= s_stop;
                r_pcnt <= (k == 2'd0) ? 2'd0 : k - 2'd1;
            end else if (r_pcnt != 2'd0 && out_free) begin
                r_pcnt <= r_pcnt - 2'd1;
            end
            if (ex_v) begin
                r_hold_v <= !ex.flush;
            end
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_pend[0] <= ev[1];
            r_pend[1] <= ev[2];
        end else if (r_pcnt != 2'd0 && out_free) begin
            r_pend[0] <= r_pend[1];
        end
        if (ex_v && !ex.flush) begin
            r_hold <= ex;
        end
        if (push) begin
            r_o_kind <= r_hold.kind;
            r_o_sym  <= r_hold.sym;
            r_o_last <= ex.flush;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_kind  = r_o_kind;
    assign o_symbol    = r_o_sym;
    assign o_run_last  = r_o_last;

    // A flush always empties the hold stage
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_v && ex.flush |=> !r_hold_v)
        else $error("hold stage not emptied by flush");

    // Once the line is ended, an op yields at most the end-of-byte flush
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_stop |-> (k == 2'd0) || ev[0].flush)
        else $error("result produced after end of line");

endmodule : sct_back
`default_nettype wire
